// ===== hdl/dcmc_pkg.sv =====
// Package for the dual curtain motor controller: request and result structs,
// register indexes, state encodings and reset values. No dependencies.
package dcmc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RUN_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_ON_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_OFF_LEVEL = 3'd4;

  // Register reset values
  localparam logic [15:0] RUN_TICKS_RST     = 16'd600;
  localparam logic [15:0] DEAD_TICKS_RST    = 16'd5;
  localparam logic [1:0]  PRESS_COUNT_RST   = 2'd2;
  localparam logic [7:0]  LED_ON_LEVEL_RST  = 8'd128;
  localparam logic [7:0]  LED_OFF_LEVEL_RST = 8'd8;

  localparam int TIMER_BITS_DEF = 16;

  // Request kinds
  localparam logic [1:0] REQ_KEY    = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_REMOTE = 2'd2;

  // Remote commands
  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  // Reported state codes
  localparam logic [2:0] CODE_STOP     = 3'd0;
  localparam logic [2:0] CODE_OPEN     = 3'd1;
  localparam logic [2:0] CODE_CLOSE    = 3'd2;
  localparam logic [2:0] CODE_TO_OPEN  = 3'd3;
  localparam logic [2:0] CODE_TO_CLOSE = 3'd4;

  // Motor state machine, one-hot
  typedef enum logic [4:0] {
    ST_STOP     = 5'b00001,
    ST_OPEN     = 5'b00010,
    ST_CLOSE    = 5'b00100,
    ST_TO_OPEN  = 5'b01000,
    ST_TO_CLOSE = 5'b10000
  } motor_st_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] key_levels;
    logic       channel;
    logic [1:0] command;
  } req_t;

  typedef struct packed {
    logic [2:0] state_a;
    logic [2:0] state_b;
    logic [3:0] relays;
    logic [7:0] led_open_a;
    logic [7:0] led_open_b;
    logic [7:0] led_close_a;
    logic [7:0] led_close_b;
    logic       changed;
  } rsp_t;

  // Per-channel control for one processed request
  typedef struct packed {
    logic       key_open;
    logic       key_close;
    logic       tick;
    logic       remote;
    logic [1:0] command;
  } ch_ctrl_t;

  // Per-channel status after the request
  typedef struct packed {
    logic [2:0] state;
    logic       changed;
  } ch_stat_t;

  function automatic logic [2:0] st_code(motor_st_e st);
    logic [2:0] code;
    case (st)
      ST_OPEN:     code = CODE_OPEN;
      ST_CLOSE:    code = CODE_CLOSE;
      ST_TO_OPEN:  code = CODE_TO_OPEN;
      ST_TO_CLOSE: code = CODE_TO_CLOSE;
      default:     code = CODE_STOP;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/dcmc_keys.sv =====
// Key debounce: four saturating hold counters and press detection.
// Does not depend on dcmc_pkg; its widths are local.
module dcmc_keys (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sample_i,
  input  logic [3:0] key_levels_i,
  input  logic [1:0] press_count_i,
  output logic [3:0] fire_o
);

  logic [1:0] cnt_q [4];
  logic [1:0] cnt_d [4];

  // Count held keys, fire on the sample that reaches the press count
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt_d[k]  = cnt_q[k];
      fire_o[k] = 1'b0;
      if (sample_i) begin
        if (!key_levels_i[k]) begin
          if (cnt_q[k] != 2'd3) begin
            cnt_d[k]  = cnt_q[k] + 2'd1;
            fire_o[k] = (cnt_d[k] == press_count_i);
          end
        end else begin
          cnt_d[k] = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) cnt_q[k] <= 2'd0;
    end else begin
      for (int k = 0; k < 4; k++) cnt_q[k] <= cnt_d[k];
    end
  end

endmodule

// ===== hdl/dcmc_channel.sv =====
// One motor channel: state machine, seen-state tracking and run/dead timer.
// Depends on dcmc_pkg (motor_st_e, ch_ctrl_t, ch_stat_t, command codes).
module dcmc_channel #(
  parameter int TIMER_BITS = dcmc_pkg::TIMER_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcmc_pkg::ch_ctrl_t ctrl_i,
  input  logic [15:0]        run_ticks_i,
  input  logic [15:0]        dead_ticks_i,
  output dcmc_pkg::ch_stat_t stat_o
);

  dcmc_pkg::motor_st_e st_q, st_d;
  dcmc_pkg::motor_st_e seen_q, seen_d;
  logic [TIMER_BITS-1:0] tmr_q, tmr_d;
  logic [TIMER_BITS-1:0] tmr_load;
  logic [TIMER_BITS-1:0] tmr_dec;
  logic                  chg;

  // Timer after a possible reload on a state change
  always_comb begin
    chg = (seen_q != st_q);
    if (!chg) begin
      tmr_load = tmr_q;
    end else if (st_q == dcmc_pkg::ST_OPEN || st_q == dcmc_pkg::ST_CLOSE) begin
      tmr_load = TIMER_BITS'(run_ticks_i);
    end else begin
      tmr_load = TIMER_BITS'(dead_ticks_i);
    end
    tmr_dec = tmr_load - TIMER_BITS'(1);
  end

  // Next state for the current request
  always_comb begin
    st_d    = st_q;
    seen_d  = seen_q;
    tmr_d   = tmr_q;
    if (ctrl_i.key_open) begin
      st_d = (st_q == dcmc_pkg::ST_STOP) ? dcmc_pkg::ST_OPEN : dcmc_pkg::ST_STOP;
    end else if (ctrl_i.key_close) begin
      st_d = (st_q == dcmc_pkg::ST_STOP) ? dcmc_pkg::ST_CLOSE : dcmc_pkg::ST_STOP;
    end else if (ctrl_i.tick) begin
      seen_d = st_q;
      tmr_d  = tmr_load;
      if (tmr_load != '0) begin
        tmr_d = tmr_dec;
        if (tmr_dec == '0) begin
          case (st_q)
            dcmc_pkg::ST_TO_CLOSE: st_d = dcmc_pkg::ST_CLOSE;
            dcmc_pkg::ST_TO_OPEN:  st_d = dcmc_pkg::ST_OPEN;
            default:               st_d = dcmc_pkg::ST_STOP;
          endcase
        end
      end
    end else if (ctrl_i.remote) begin
      case (ctrl_i.command)
        dcmc_pkg::CMD_OPEN: begin
          if (st_q == dcmc_pkg::ST_STOP || st_q == dcmc_pkg::ST_TO_CLOSE) begin
            st_d = dcmc_pkg::ST_OPEN;
          end else if (st_q == dcmc_pkg::ST_CLOSE) begin
            st_d = dcmc_pkg::ST_TO_OPEN;
          end
        end
        dcmc_pkg::CMD_STOP: st_d = dcmc_pkg::ST_STOP;
        dcmc_pkg::CMD_CLOSE: begin
          if (st_q == dcmc_pkg::ST_STOP || st_q == dcmc_pkg::ST_TO_OPEN) begin
            st_d = dcmc_pkg::ST_CLOSE;
          end else if (st_q == dcmc_pkg::ST_OPEN) begin
            st_d = dcmc_pkg::ST_TO_CLOSE;
          end
        end
        default: st_d = st_q;  // unused command
      endcase
    end
  end

  assign stat_o.state   = dcmc_pkg::st_code(st_d);
  assign stat_o.changed = ctrl_i.tick & chg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= dcmc_pkg::ST_STOP;
      seen_q <= dcmc_pkg::ST_STOP;
      tmr_q  <= '0;
    end else begin
      st_q   <= st_d;
      seen_q <= seen_d;
      tmr_q  <= tmr_d;
    end
  end

endmodule

// ===== hdl/dual_curtain_motor_controller.sv =====
// Top level of the dual curtain motor controller; uses dcmc_pkg, dcmc_keys, dcmc_channel.
// Flow: a request is captured in the input register, and its result is registered in the
// output register when the result slot is free or its result is being taken.
// Throughput: one request per cycle. A stalled result stops processing; the input
// register takes one more request, then ready drops until the result is taken.
// Reset clears key counters, motor states and timers and loads the register defaults.
module dual_curtain_motor_controller #(
  parameter int TIMER_BITS = dcmc_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dcmc_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dcmc_pkg::rsp_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [dcmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dcmc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [15:0] run_ticks_q, dead_ticks_q;
  logic [1:0]  press_count_q;
  logic [7:0]  led_on_q, led_off_q;

  logic           in_valid_q;
  dcmc_pkg::req_t in_q;
  logic           out_valid_q;
  dcmc_pkg::rsp_t out_q, out_d;
  logic           advance;
  logic           key_sample;
  logic [3:0]     fire;

  dcmc_pkg::ch_ctrl_t ctrl_a, ctrl_b;
  dcmc_pkg::ch_stat_t stat_a, stat_b;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_ticks_q   <= dcmc_pkg::RUN_TICKS_RST;
      dead_ticks_q  <= dcmc_pkg::DEAD_TICKS_RST;
      press_count_q <= dcmc_pkg::PRESS_COUNT_RST;
      led_on_q      <= dcmc_pkg::LED_ON_LEVEL_RST;
      led_off_q     <= dcmc_pkg::LED_OFF_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dcmc_pkg::CFG_RUN_TICKS:     run_ticks_q   <= cfg_wdata_i;
        dcmc_pkg::CFG_DEAD_TICKS:    dead_ticks_q  <= cfg_wdata_i;
        dcmc_pkg::CFG_PRESS_COUNT:   press_count_q <= cfg_wdata_i[1:0];
        dcmc_pkg::CFG_LED_ON_LEVEL:  led_on_q      <= cfg_wdata_i[7:0];
        dcmc_pkg::CFG_LED_OFF_LEVEL: led_off_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: process the held request when the result slot is free or being taken
  assign advance     = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~in_valid_q | advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (advance) out_q <= out_d;
  end

  // Decode request into per-channel controls
  assign key_sample = advance & (in_q.req_type == dcmc_pkg::REQ_KEY);

  always_comb begin
    ctrl_a.key_open  = fire[0];
    ctrl_a.key_close = fire[2];
    ctrl_b.key_open  = fire[1];
    ctrl_b.key_close = fire[3];
    ctrl_a.tick      = 1'b0;
    ctrl_a.remote    = 1'b0;
    ctrl_b.tick      = 1'b0;
    ctrl_b.remote    = 1'b0;
    ctrl_a.command   = in_q.command;
    ctrl_b.command   = in_q.command;
    if (advance) begin
      case (in_q.req_type)
        dcmc_pkg::REQ_TICK: begin
          ctrl_a.tick = 1'b1;
          ctrl_b.tick = 1'b1;
        end
        dcmc_pkg::REQ_REMOTE: begin
          ctrl_a.remote = ~in_q.channel;
          ctrl_b.remote = in_q.channel;
        end
        default: ;  // key samples via fire, unused type does nothing
      endcase
    end
  end

  dcmc_keys u_keys (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_i      (key_sample),
    .key_levels_i  (in_q.key_levels),
    .press_count_i (press_count_q),
    .fire_o        (fire)
  );

  dcmc_channel #(.TIMER_BITS(TIMER_BITS)) u_chan_a (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl_a),
    .run_ticks_i  (run_ticks_q),
    .dead_ticks_i (dead_ticks_q),
    .stat_o       (stat_a)
  );

  dcmc_channel #(.TIMER_BITS(TIMER_BITS)) u_chan_b (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl_b),
    .run_ticks_i  (run_ticks_q),
    .dead_ticks_i (dead_ticks_q),
    .stat_o       (stat_b)
  );

  // Result: states after the request, relay bits and LED levels
  always_comb begin
    out_d.state_a   = stat_a.state;
    out_d.state_b   = stat_b.state;
    out_d.relays[0] = (stat_a.state == dcmc_pkg::CODE_OPEN);
    out_d.relays[1] = (stat_a.state == dcmc_pkg::CODE_CLOSE);
    out_d.relays[2] = (stat_b.state == dcmc_pkg::CODE_OPEN);
    out_d.relays[3] = (stat_b.state == dcmc_pkg::CODE_CLOSE);
    out_d.led_open_a  = out_d.relays[0] ? led_on_q : led_off_q;
    out_d.led_close_a = out_d.relays[1] ? led_on_q : led_off_q;
    out_d.led_open_b  = out_d.relays[2] ? led_on_q : led_off_q;
    out_d.led_close_b = out_d.relays[3] ? led_on_q : led_off_q;
    out_d.changed     = stat_a.changed | stat_b.changed;
  end

endmodule

// ===== hdl/dcmc_checker.sv =====
// Port-level checks for the dual curtain motor controller, bound to the top.
// Depends on dcmc_pkg (structs and state codes).
module dcmc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input dcmc_pkg::req_t                  in_data_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input dcmc_pkg::rsp_t                  out_data_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A waiting request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("request changed while waiting");

  // An empty result slot never blocks requests
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request blocked with empty result slot");

  // A request into an idle output yields a valid result once through the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##2 out_valid_o)
    else $error("result missing after request");

  // Relay interlock and agreement with the reported states
  a_relays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.relays[0] == (out_data_o.state_a == dcmc_pkg::CODE_OPEN)) &&
      (out_data_o.relays[1] == (out_data_o.state_a == dcmc_pkg::CODE_CLOSE)) &&
      (out_data_o.relays[2] == (out_data_o.state_b == dcmc_pkg::CODE_OPEN)) &&
      (out_data_o.relays[3] == (out_data_o.state_b == dcmc_pkg::CODE_CLOSE)))
    else $error("relay bits disagree with motor states");

endmodule

bind dual_curtain_motor_controller dcmc_checker u_dcmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
